FILE: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types of the JSON string unescaper
// Payload structs of the input and result channels.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // One byte of the escaped string body.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } jsu_in_t;

    // One unescaped result byte or an empty end-of-string marker.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
    } jsu_out_t;

endpackage

FILE: sv/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top: streaming JSON string unescaper
// Decodes backslash escapes and \uXXXX code points to UTF-8, one byte in.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data move one byte of the string body per transfer;
//   is_final marks the last byte. m_valid/m_ready/m_data move one result
//   byte per transfer; run_last marks the last result of an input byte and
//   string_done the last result of the string. A final byte that yields no
//   data gives one marker result with byte_valid low.
// Latency and throughput:
//   An input byte is decoded in the cycle it is taken; its first result
//   shows on m_data in the next cycle. The run register holds up to four
//   result bytes and drains one per cycle while m_ready is high; a byte
//   with several results holds off the next until they drain, and bytes
//   yielding one result or none flow at one per cycle while m_ready is high.
//   A new byte is taken as the last result of the previous run transfers.
// Reset and stalls:
//   aresetn (synchronous, active low) returns the decoder to plain text and
//   empties the run register. While m_ready is low the current result holds
//   and s_ready stays low once the run register is occupied.
// ----------------------------------------------------------------------------
module json_string_unescape_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jsu_pkg::jsu_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output jsu_pkg::jsu_out_t  m_data
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_FF    = 8'h0C;
    localparam logic [7:0] CTL_LF    = 8'h0A;
    localparam logic [7:0] CTL_CR    = 8'h0D;
    localparam logic [7:0] CTL_TAB   = 8'h09;
    localparam logic [1:0] LAST_DIGIT = 2'd3;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    // Decoder state
    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];

    // Run register: pending result bytes, shifted out at index 0
    logic [7:0]  run_byte_reg [4];
    logic [7:0]  run_byte_next [4];
    logic [2:0]  run_left_reg, run_left_next;
    logic        run_marker_reg, run_marker_next;
    logic        run_fin_reg, run_fin_next;

    // Decode results of the byte at the input
    logic [7:0]  dec_byte [4];
    logic [2:0]  dec_n;
    logic        dec_marker;
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] hex_acc;
    logic [7:0]  c;

    logic        drain;
    logic        accept;

    assign c = s_data.in_byte;

    always_comb begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_digit = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_digit = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_digit = 4'(c - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc = {hex_reg[11:0], hex_digit};

    always_comb begin
        dec_byte   = '{default: 8'h00};
        dec_n      = 3'd0;
        dec_marker = 1'b0;
        mode_next  = mode_reg;
        hex_next   = hex_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;

        unique case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_TEXT;
                if (c == CH_U) begin
                    mode_next = MODE_HEX;
                    cnt_next  = 2'd0;
                    hex_next  = 16'h0000;
                end else begin
                    dec_n = 3'd1;
                    unique case (c)
                        CH_B:    dec_byte[0] = CTL_BS;
                        CH_F:    dec_byte[0] = CTL_FF;
                        CH_N:    dec_byte[0] = CTL_LF;
                        CH_R:    dec_byte[0] = CTL_CR;
                        CH_T:    dec_byte[0] = CTL_TAB;
                        default: dec_byte[0] = c;
                    endcase
                end
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    if (cnt_reg == LAST_DIGIT) begin
                        // encode the code point as UTF-8
                        if (hex_acc < 16'h0080) begin
                            dec_byte[0] = hex_acc[7:0];
                            dec_n       = 3'd1;
                        end else if (hex_acc < 16'h0800) begin
                            dec_byte[0] = {3'b110, hex_acc[10:6]};
                            dec_byte[1] = {2'b10, hex_acc[5:0]};
                            dec_n       = 3'd2;
                        end else begin
                            dec_byte[0] = {4'b1110, hex_acc[15:12]};
                            dec_byte[1] = {2'b10, hex_acc[11:6]};
                            dec_byte[2] = {2'b10, hex_acc[5:0]};
                            dec_n       = 3'd3;
                        end
                        cnt_next  = 2'd0;
                        hex_next  = 16'h0000;
                        mode_next = MODE_TEXT;
                    end else begin
                        held_next[cnt_reg] = c;
                        cnt_next           = cnt_reg + 2'd1;
                        hex_next           = hex_acc;
                    end
                end else begin
                    // incomplete escape: pass the held digits, then treat as text
                    for (int i = 0; i < 3; i++) begin
                        dec_byte[i] = held_reg[i];
                    end
                    dec_n     = {1'b0, cnt_reg};
                    cnt_next  = 2'd0;
                    hex_next  = 16'h0000;
                    mode_next = MODE_TEXT;
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        dec_byte[cnt_reg] = c;
                        dec_n             = {1'b0, cnt_reg} + 3'd1;
                    end
                end
            end
            default: begin
                if (c == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    dec_byte[0] = c;
                    dec_n       = 3'd1;
                end
            end
        endcase

        if (s_data.is_final) begin
            // still collecting digits here implies nothing was emitted yet
            if (mode_next == MODE_HEX) begin
                for (int i = 0; i < 3; i++) begin
                    dec_byte[i] = held_next[i];
                end
                dec_n = {1'b0, cnt_next};
            end
            mode_next = MODE_TEXT;
            cnt_next  = 2'd0;
            hex_next  = 16'h0000;
            if (dec_n == 3'd0) begin
                dec_byte[0] = 8'h00;
                dec_n       = 3'd1;
                dec_marker  = 1'b1;
            end
        end
    end

    assign m_valid = (run_left_reg != 3'd0);
    assign drain   = m_valid && m_ready;
    assign s_ready = (run_left_reg == 3'd0) || (m_ready && run_left_reg == 3'd1);
    assign accept  = s_valid && s_ready;

    assign m_data.out_byte    = run_byte_reg[0];
    assign m_data.byte_valid  = !run_marker_reg;
    assign m_data.run_last    = (run_left_reg == 3'd1);
    assign m_data.string_done = (run_left_reg == 3'd1) && run_fin_reg;

    always_comb begin
        run_byte_next   = run_byte_reg;
        run_left_next   = run_left_reg;
        run_marker_next = run_marker_reg;
        run_fin_next    = run_fin_reg;
        if (accept) begin
            // a byte that yields nothing leaves the run register empty
            run_byte_next   = dec_byte;
            run_left_next   = dec_n;
            run_marker_next = dec_marker;
            run_fin_next    = s_data.is_final;
        end else if (drain) begin
            for (int i = 0; i < 3; i++) begin
                run_byte_next[i] = run_byte_reg[i + 1];
            end
            run_left_next = run_left_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_TEXT;
            hex_reg      <= 16'h0000;
            cnt_reg      <= 2'd0;
            run_left_reg <= 3'd0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                hex_reg  <= hex_next;
                cnt_reg  <= cnt_next;
            end
            run_left_reg <= run_left_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
        run_byte_reg   <= run_byte_next;
        run_marker_reg <= run_marker_next;
        run_fin_reg    <= run_fin_next;
    end

endmodule

FILE: sv/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks of the JSON string unescaper
// Watches the result channel framing and the input/output coupling.
// ----------------------------------------------------------------------------
module jsu_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  jsu_pkg::jsu_in_t   s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  jsu_pkg::jsu_out_t  m_data
);
    import jsu_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_marker_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.run_last && m_data.string_done)
        else $error("empty marker not at end of string");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_done |-> m_data.run_last)
        else $error("string_done without run_last");

    // a new byte is taken only while the last result of a run leaves
    a_ready_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && s_ready |-> m_ready && m_data.run_last)
        else $error("input taken while a run is still pending");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (.*);
